// File: design/vertex_transform_defines.svh
// Assertion macros for the vertex transform RTL (used by vt_back).
// No dependencies.
`ifndef VERTEX_TRANSFORM_DEFINES_SVH
`define VERTEX_TRANSFORM_DEFINES_SVH
// implication checked on every edge out of reset
`define VT_ASSERT_IMP(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("label failed");
// next-cycle implication
`define VT_ASSERT_NEXT(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("label failed");
`endif

// File: design/vt_pkg.sv
// Package for the vertex transform: widths, codes, default matrices, helpers.
// No dependencies.
`default_nettype none
package vt_pkg;
  localparam int FRAC_BITS = 16;
  localparam int QUEUE_DEPTH = 4;
  localparam int QW = $clog2(QUEUE_DEPTH);
  // dividend bits of the perspective divide: |num| (33 bits) << FRAC_BITS
  localparam int DIV_W = 33 + FRAC_BITS;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_VERTEX = 1'b1;
  localparam logic MAT_MODEL = 1'b0;
  localparam logic MAT_PROJ = 1'b1;

  localparam logic [1:0] REG_WIDTH = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;

  localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] S32_MIN = 32'sh80000000;

  typedef struct packed {
    logic       command;
    logic       which_matrix;
    logic [3:0] index;
    logic signed [31:0] coeff_value;
    logic signed [31:0] vertex_x;
    logic signed [31:0] vertex_y;
    logic signed [31:0] vertex_z;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MAT, ST_DIV, ST_POST, ST_OUT
  } state_t;

  // micro units to fixed point, nearest, ties away from zero
  function automatic logic signed [31:0] from_micro(input longint m);
    longint mag;
    longint q;
    mag = (m < 0) ? -m : m;
    q = ((mag <<< FRAC_BITS) + 64'sd500000) / 64'sd1000000;
    from_micro = (m < 0) ? 32'(-q) : 32'(q);
  endfunction

  function automatic logic signed [31:0] model_default(input logic [3:0] i);
    case (i)
      4'd0, 4'd5, 4'd10, 4'd15: model_default = from_micro(64'sd1000000);
      4'd11: model_default = from_micro(-64'sd3000000);
      default: model_default = '0;
    endcase
  endfunction

  function automatic logic signed [31:0] proj_default(input logic [3:0] i);
    case (i)
      4'd0: proj_default = from_micro(64'sd1810660);
      4'd5: proj_default = from_micro(64'sd2414214);
      4'd10: proj_default = from_micro(-64'sd1020202);
      4'd11: proj_default = from_micro(-64'sd202020);
      4'd14: proj_default = from_micro(-64'sd1000000);
      default: proj_default = '0;
    endcase
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
    if (x > 66'sh0_7fff_ffff) sat32 = S32_MAX;
    else if (x < -66'sh0_8000_0000) sat32 = S32_MIN;
    else sat32 = x[31:0];
  endfunction
endpackage
`default_nettype wire

// File: design/vt_front.sv
// Front end: accepts items, writes every item (coefficient loads and vertices) into a small queue.
// Depends on vt_pkg.
`default_nettype none
module vt_front import vt_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire item_t in_item,
  output logic       q_valid,
  input  wire logic  q_pop,
  output item_t      q_item
);
  item_t slots [QUEUE_DEPTH];
  logic [QW-1:0] wr_ptr;
  logic [QW-1:0] rd_ptr;
  logic [QW:0] count;
  logic push;

  assign in_ready = (count != (QW+1)'(QUEUE_DEPTH));
  assign push = in_valid && in_ready;
  assign q_valid = (count != '0);
  assign q_item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (q_pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (QW+1)'(push) - (QW+1)'(q_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= in_item;
  end
endmodule
`default_nettype wire

// File: design/vt_back.sv
// Back end: coefficient store, shared multiplier, serial divider, viewport.
// Depends on vt_pkg and vertex_transform_defines.svh.
`default_nettype none
`include "vertex_transform_defines.svh"
module vt_back import vt_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        q_valid,
  output logic             q_pop,
  input  wire item_t       q_item,
  input  wire logic [12:0] vp_width,
  input  wire logic [12:0] vp_height,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [128:0]     out_data
);
  logic signed [31:0] mcoef [16];
  logic signed [31:0] pcoef [16];
  logic [15:0] mwr;
  logic [15:0] pwr;

  state_t state;
  state_t state_next;

  logic       pass;       // 0 model, 1 projection
  logic [3:0] step;       // row*4+col of current product
  logic signed [31:0] vin [4];
  logic signed [31:0] vres [4];
  logic signed [65:0] acc;
  logic signed [63:0] prod;
  logic        prod_ok;
  logic [3:0]  prod_idx;

  // divider: restoring, one quotient bit per cycle
  logic [1:0]  dsel;
  logic [6:0]  dbit;
  logic [DIV_W-1:0] dnum;  // |num| << FRAC_BITS
  logic [31:0] dden;       // |w|
  logic [DIV_W:0] drem;
  logic [DIV_W-1:0] dquo;
  logic        dneg;
  logic signed [31:0] nres [3];
  logic        div_done;

  logic [1:0]  post_sel;
  logic signed [31:0] ox, oy, oz;
  logic        ozero;

  logic do_load;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] term;
  logic [DIV_W:0] drem_sh;

  assign do_load = (state == ST_IDLE) && q_valid && (q_item.command == CMD_LOAD);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (q_valid && q_item.command == CMD_VERTEX) state_next = ST_MAT;
      ST_MAT: if (prod_ok && prod_idx == 4'd15 && pass) state_next = ST_DIV;
      ST_DIV: if (vres[3] == '0 || div_done) state_next = ST_POST;
      ST_POST: if (post_sel == 2'd2) state_next = ST_OUT;
      ST_OUT: if (out_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop = 1'b0;
    out_valid = 1'b0;
    case (state)
      ST_IDLE: q_pop = q_valid;
      ST_OUT: out_valid = 1'b1;
      default: begin
        q_pop = 1'b0;
        out_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // coefficient store; the write flags let unwritten entries read the default
  always_ff @(posedge clk) begin
    if (rst) begin
      mwr <= '0;
      pwr <= '0;
    end else if (do_load) begin
      if (q_item.which_matrix == MAT_PROJ) pwr[q_item.index] <= 1'b1;
      else mwr[q_item.index] <= 1'b1;
    end
  end
  always_ff @(posedge clk) begin
    if (do_load) begin
      if (q_item.which_matrix == MAT_PROJ) pcoef[q_item.index] <= q_item.coeff_value;
      else mcoef[q_item.index] <= q_item.coeff_value;
    end
  end

  always_comb begin
    if (pass) mul_a = pwr[step] ? pcoef[step] : proj_default(step);
    else mul_a = mwr[step] ? mcoef[step] : model_default(step);
    mul_b = vin[step[1:0]];
  end

  // rounded product term: (p + half) >>> FRAC_BITS
  assign term = (prod + (64'sd1 <<< (FRAC_BITS-1))) >>> FRAC_BITS;
  assign drem_sh = {drem[DIV_W-1:0], dnum[dbit[5:0]]};

  // an empty product slot at the start of each pass while its input vector loads
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_ok <= 1'b0;
    end else begin
      prod_ok <= (state == ST_MAT) && !(prod_ok && prod_idx == 4'd15);
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        pass <= 1'b0;
        step <= '0;
        vin[0] <= q_item.vertex_x;
        vin[1] <= q_item.vertex_y;
        vin[2] <= q_item.vertex_z;
        vin[3] <= 32'sd1 <<< FRAC_BITS;
        acc <= '0;
        dsel <= '0;
        post_sel <= '0;
        div_done <= 1'b0;
        dbit <= 7'd127;
      end
      ST_MAT: begin
        prod <= mul_a * mul_b;
        prod_idx <= step;
        step <= step + 1'b1;
        if (prod_ok) begin
          if (prod_idx[1:0] == 2'd3) begin
            vres[prod_idx[3:2]] <= sat32(66'(acc + term));
            acc <= '0;
          end else begin
            acc <= acc + term;
          end
          if (prod_idx == 4'd15 && !pass) begin
            // model result becomes the projection input
            pass <= 1'b1;
            step <= '0;
            vin[0] <= vres[0];
            vin[1] <= vres[1];
            vin[2] <= vres[2];
            vin[3] <= sat32(66'(acc + term));
          end
        end
      end
      ST_DIV: begin
        if (dbit == 7'd127) begin
          dnum <= {33'(vres[dsel][31] ? -33'(vres[dsel]) : 33'(vres[dsel])),
                   {FRAC_BITS{1'b0}}};
          dden <= vres[3][31] ? 32'(-vres[3]) : 32'(vres[3]);
          dneg <= vres[dsel][31] ^ vres[3][31];
          drem <= '0;
          dquo <= '0;
          dbit <= 7'(DIV_W - 1);
        end else if (dbit == 7'd126) begin
          nres[dsel] <= sat32(dneg ? -66'(dquo) : 66'(dquo));
          dbit <= 7'd127;
          if (dsel == 2'd2) div_done <= 1'b1;
          else dsel <= dsel + 1'b1;
        end else begin
          if (drem_sh >= (DIV_W+1)'(dden)) begin
            drem <= drem_sh - (DIV_W+1)'(dden);
            dquo[dbit[5:0]] <= 1'b1;
          end else begin
            drem <= drem_sh;
          end
          if (dbit == 7'd0) dbit <= 7'd126;
          else dbit <= dbit - 1'b1;
        end
      end
      ST_POST: begin
        post_sel <= post_sel + 1'b1;
        ozero <= (vres[3] == '0);
        case (post_sel)
          2'd0: ox <= vres[3] == '0 ? (vres[0][31] ? S32_MIN : S32_MAX) :
                sat32(66'((($signed({1'b0, 32'd1 <<< FRAC_BITS}) + 34'(nres[0])) *
                  $signed({1'b0, (vp_width == 0 ? 13'd0 : vp_width - 1'b1)}))
                  >>> 1));
          2'd1: oy <= vres[3] == '0 ? (vres[1][31] ? S32_MIN : S32_MAX) :
                sat32(66'((($signed({1'b0, 32'd1 <<< FRAC_BITS}) + 34'(nres[1])) *
                  $signed({1'b0, (vp_height == 0 ? 13'd0 : vp_height - 1'b1)}))
                  >>> 1));
          default: oz <= vres[3] == '0 ? (vres[2][31] ? S32_MIN : S32_MAX) :
                sat32(66'(($signed({1'b0, 32'd1 <<< FRAC_BITS}) + 34'(nres[2])) >>> 1));
        endcase
      end
      default: ;
    endcase
  end

  assign out_data = {ozero, vres[3], oz, oy, ox};

  `VT_ASSERT_IMP(a_out_only_in_out, out_valid, state == ST_OUT)
  `VT_ASSERT_IMP(a_no_pop_busy, q_pop, state == ST_IDLE)
  `VT_ASSERT_NEXT(a_out_holds, out_valid && !out_ready, out_valid && $stable(out_data))
endmodule
`default_nettype wire

// File: design/vertex_transform.sv
// Vertex transform top: APB registers, front queue and back end (vt_pkg, vt_front, vt_back).
// Each vertex runs two matrix passes on one multiplier, three restoring divides, the viewport
// steps and the handoff; the divides are skipped when clip w is zero. The back end takes no
// new vertex until the last is output; coeff loads are taken one per cycle while it is idle.
// Reset (rst, sync, high): queue empty, matrices at defaults, 640x480.
`default_nettype none
module vertex_transform import vt_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [135:0] s_axis_tdata, // coeff_row,coeff_col,value,x,y,z,pad
  input  wire logic [1:0]   s_axis_tuser, // command, which_matrix
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [127:0]      m_axis_tdata, // screen_x,screen_y,depth,clip_w
  output logic              m_axis_tuser, // w_zero
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  logic [12:0] vp_width;
  logic [12:0] vp_height;
  item_t in_item;
  item_t q_item;
  logic q_valid;
  logic q_pop;
  logic [128:0] odata;

  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      vp_width <= 13'd640;
      vp_height <= 13'd480;
    end else if (psel && penable && pwrite) begin
      if (paddr == {REG_WIDTH[0], 2'b00}) vp_width <= pwdata[12:0];
      else if (paddr == {REG_HEIGHT[0], 2'b00}) vp_height <= pwdata[12:0];
    end
  end
  always_comb begin
    case (paddr)
      {REG_WIDTH[0], 2'b00}: prdata = {19'd0, vp_width};
      {REG_HEIGHT[0], 2'b00}: prdata = {19'd0, vp_height};
      default: prdata = '0;
    endcase
  end

  always_comb begin
    in_item.command = s_axis_tuser[0];
    in_item.which_matrix = s_axis_tuser[1];
    in_item.index = {s_axis_tdata[1:0], s_axis_tdata[3:2]};
    in_item.coeff_value = s_axis_tdata[35:4];
    in_item.vertex_x = s_axis_tdata[67:36];
    in_item.vertex_y = s_axis_tdata[99:68];
    in_item.vertex_z = s_axis_tdata[131:100];
  end

  vt_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_item(in_item),
    .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item)
  );

  vt_back u_back (
    .clk(clk), .rst(rst),
    .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item),
    .vp_width(vp_width), .vp_height(vp_height),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(odata)
  );

  assign m_axis_tdata = odata[127:0];
  assign m_axis_tuser = odata[128];
endmodule
`default_nettype wire
